// ===== sv/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg: shared definitions for the life grid generation step
// Grid size, command codes, the row word type and the B3/S23 cell rule.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int GRID_WIDTH  = 32;
    localparam int GRID_HEIGHT = 32;

    localparam int COL_W = $clog2(GRID_WIDTH);
    localparam int ROW_W = $clog2(GRID_HEIGHT);

    localparam int CMD_W = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef logic [GRID_WIDTH-1:0] row_word_t;

    // Next state of one cell from its 3x3 neighborhood, given as three
    // three-bit slices; the center bit of the middle slice is the cell.
    function automatic logic life_rule(input logic [2:0] above,
                                       input logic [2:0] middle,
                                       input logic [2:0] below);
        logic [3:0] count;
        count = 4'd0;
        for (int i = 0; i < 3; i++)
        begin
            count = count + {3'd0, above[i]} + {3'd0, below[i]};
        end
        count = count + {3'd0, middle[0]} + {3'd0, middle[2]};
        if (middle[1])
            life_rule = (count == SURVIVE_COUNT) || (count == BIRTH_COUNT);
        else
            life_rule = (count == BIRTH_COUNT);
    endfunction

endpackage

// ===== sv/life_grid_generation_step.sv =====
// ----------------------------------------------------------------------------
// life_grid_generation_step: bounded Conway B3/S23 grid with one-cell updates
// Write, read or advance the grid by one generation; report one cell.
// ----------------------------------------------------------------------------
// A write or read item goes through S_LOOK and S_LOOK_W after the edge that accepts
// it, then raises done. A step item primes row 0 (S_PRIME, S_PRIME_W), then per row
// fetches the row below (S_FETCH, S_FETCH_W), takes each cell through the single
// neighbor-count unit (S_CALC) and writes the new row back (S_STORE), then does the lookup
// (S_LOOK, S_LOOK_W). busy falls in the done cycle; no new item is taken while busy.
// Results cannot be stalled; reset clears the per-row valid bits, so all cells read dead.
module life_grid_generation_step
    import lgs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CMD_W-1:0] cmd,
    input  logic [4:0]       col,
    input  logic [4:0]       row,
    input  logic             cell_value,
    output logic             done,
    output logic             cell_alive
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PRIME   = 4'd1;
    localparam logic [3:0] S_PRIME_W = 4'd2;
    localparam logic [3:0] S_FETCH   = 4'd3;
    localparam logic [3:0] S_FETCH_W = 4'd4;
    localparam logic [3:0] S_CALC    = 4'd5;
    localparam logic [3:0] S_STORE   = 4'd6;
    localparam logic [3:0] S_LOOK    = 4'd7;
    localparam logic [3:0] S_LOOK_W  = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             val_reg, val_next;
    logic             inside_reg, inside_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    row_word_t        above_reg, above_next;
    row_word_t        cur_reg, cur_next;
    row_word_t        below_reg, below_next;
    row_word_t        new_row_reg, new_row_next;
    logic             done_reg, done_next;
    logic             alive_reg, alive_next;

    // Row memory with one write and one registered read port.
    row_word_t              mem [GRID_HEIGHT];
    logic [GRID_HEIGHT-1:0] row_valid_reg;
    row_word_t              rd_word_reg;
    logic                   rd_ok_reg;
    logic [ROW_W-1:0]       rd_addr;
    logic [ROW_W-1:0]       wr_addr;
    row_word_t              wr_data;
    logic                   wr_en;
    row_word_t              rd_data;

    logic [GRID_WIDTH+1:0] pad_above, pad_cur, pad_below;
    logic [COL_W:0]        win_idx;
    logic                  cell_next;
    logic                  last_row, last_col;
    row_word_t             patched;

    assign rd_data = rd_ok_reg ? rd_word_reg : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
                row_valid_reg[wr_addr] <= 1'b1;
            rd_ok_reg <= row_valid_reg[rd_addr];
        end
    end

    // Neighbor window of the current column; the padding makes the edges dead.
    assign pad_above = {1'b0, above_reg, 1'b0};
    assign pad_cur   = {1'b0, cur_reg, 1'b0};
    assign pad_below = {1'b0, below_reg, 1'b0};
    assign win_idx   = {1'b0, col_cnt_reg};
    assign cell_next = life_rule(pad_above[win_idx +: 3], pad_cur[win_idx +: 3],
                                 pad_below[win_idx +: 3]);

    assign last_row = (row_cnt_reg == ROW_W'(GRID_HEIGHT - 1));
    assign last_col = (col_cnt_reg == COL_W'(GRID_WIDTH - 1));

    always_comb
    begin
        patched          = rd_data;
        patched[col_reg] = val_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        val_next     = val_reg;
        inside_next  = inside_reg;
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        above_next   = above_reg;
        cur_next     = cur_reg;
        below_next   = below_reg;
        new_row_next = new_row_reg;
        done_next    = 1'b0;
        alive_next   = alive_reg;
        rd_addr      = row_reg;
        wr_addr      = row_reg;
        wr_data      = patched;
        wr_en        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    col_next    = col[COL_W-1:0];
                    row_next    = row[ROW_W-1:0];
                    val_next    = cell_value;
                    inside_next = (int'(col) < GRID_WIDTH) && (int'(row) < GRID_HEIGHT);
                    if (cmd == CMD_STEP)
                    begin
                        row_cnt_next = '0;
                        above_next   = '0;
                        state_next   = S_PRIME;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_PRIME:
            begin
                rd_addr    = '0;
                state_next = S_PRIME_W;
            end
            S_PRIME_W:
            begin
                cur_next   = rd_data;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                rd_addr    = row_cnt_reg + 1'b1;
                state_next = S_FETCH_W;
            end
            S_FETCH_W:
            begin
                below_next   = last_row ? '0 : rd_data;
                col_cnt_next = '0;
                state_next   = S_CALC;
            end
            S_CALC:
            begin
                new_row_next = {cell_next, new_row_reg[GRID_WIDTH-1:1]};
                col_cnt_next = col_cnt_reg + 1'b1;
                if (last_col)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                // The old rows stay in the buffers, so the new row can go back now.
                wr_en      = 1'b1;
                wr_addr    = row_cnt_reg;
                wr_data    = new_row_reg;
                above_next = cur_reg;
                cur_next   = below_reg;
                if (last_row)
                begin
                    state_next = S_LOOK;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                    state_next   = S_FETCH;
                end
            end
            S_LOOK:
            begin
                state_next = S_LOOK_W;
            end
            S_LOOK_W:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (!inside_reg)
                begin
                    alive_next = 1'b0;
                end
                else if (cmd_reg == CMD_WRITE)
                begin
                    wr_en      = 1'b1;
                    alive_next = val_reg;
                end
                else
                begin
                    alive_next = rd_data[col_reg];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        val_reg     <= val_next;
        inside_reg  <= inside_next;
        row_cnt_reg <= row_cnt_next;
        col_cnt_reg <= col_cnt_next;
        above_reg   <= above_next;
        cur_reg     <= cur_next;
        below_reg   <= below_next;
        new_row_reg <= new_row_next;
        alive_reg   <= alive_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign cell_alive = alive_reg;

endmodule
